// ----- design/ccmt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccmt_pkg
// Shared types and constants of the cost curve minimum tracker.
// ----------------------------------------------------------------------------
package ccmt_pkg;

   localparam int PIXEL_W     = 16;
   localparam int STEP_W      = 10;
   localparam int COST_W      = 16;
   localparam int OLDER_W     = 17;
   localparam int FLAT_W      = 11;
   localparam int CENTER_W    = 10;
   localparam int SCORE_W     = 36;
   localparam int WEIGHT_W    = 16;
   localparam int PROD_A_W    = 27;
   localparam int PROD_B_W    = 33;
   localparam int REPORTED    = 3;
   localparam int COUNT_OUT_W = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int RSP_DEPTH   = 4;

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_READ   = 1'b1;

   localparam logic [OLDER_W-1:0]       COST_NONE         = 17'h10000;
   localparam logic signed [FLAT_W-1:0] FLAT_NONE         = -11'sd1;
   localparam logic [WEIGHT_W-1:0]      CENTER_WEIGHT_RST = 16'd0;
   localparam logic [WEIGHT_W-1:0]      COST_WEIGHT_RST   = 16'd256;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CENTER_WEIGHT = 2'd0,
      CSR_COST_WEIGHT   = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [COST_W-1:0]         last_cost;
      logic [OLDER_W-1:0]        older_cost;
      logic signed [FLAT_W-1:0]  flat_start;
   } curve_state_type;

   typedef struct packed {
      logic [CENTER_W-1:0]       center;
      logic signed [SCORE_W-1:0] score;
   } minimum_type;

   typedef struct packed {
      logic                record;
      logic [CENTER_W-1:0] center;
   } record_type;

   typedef struct packed {
      logic [PIXEL_W-1:0]                     read_pixel;
      logic [COUNT_OUT_W-1:0]                 minima_count;
      logic [REPORTED-1:0][CENTER_W-1:0]      center;
      logic [REPORTED-1:0][SCORE_W-1:0]       score;
   } rsp_type;

endpackage

// ----- design/cost_curve_minimum_tracker_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cost_curve_minimum_tracker_unit
// Per pixel cost curve follower keeping the best weighted local minima.
// ----------------------------------------------------------------------------
// The block takes one item per clock while req_ready is high. Pixel state
// (last cost, older cost, plateau start, minima count) lives in one RAM word
// per pixel and the kept minima of a pixel in one wide word of a second RAM;
// each item reads both at acceptance, updates the pixel word in the next
// cycle and the minima word from stage 2, with forwarding so that items for
// the same pixel may follow each other back to back. A read answers through
// stage 2 and a four entry response queue; req_ready drops only while that
// queue and the reads in flight would exceed its room. The RAMs are not
// cleared: a pixel entry must see a step 0 update before any other access.
// ----------------------------------------------------------------------------
module cost_curve_minimum_tracker_unit #(
   parameter int PIXEL_COUNT = 65536,
   parameter int SHIFT_STEPS = 1024,
   parameter int MINIMA_KEPT = 3
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_op,
   input  logic [ccmt_pkg::PIXEL_W-1:0]           req_pixel_index,
   input  logic [ccmt_pkg::STEP_W-1:0]            req_shift_step,
   input  logic [ccmt_pkg::COST_W-1:0]            req_pixel_cost,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [ccmt_pkg::PIXEL_W-1:0]           rsp_read_pixel,
   output logic [ccmt_pkg::COUNT_OUT_W-1:0]       rsp_minima_count,
   output logic [ccmt_pkg::CENTER_W-1:0]          rsp_center_a,
   output logic [ccmt_pkg::CENTER_W-1:0]          rsp_center_b,
   output logic [ccmt_pkg::CENTER_W-1:0]          rsp_center_c,
   output logic signed [ccmt_pkg::SCORE_W-1:0]    rsp_score_a,
   output logic signed [ccmt_pkg::SCORE_W-1:0]    rsp_score_b,
   output logic signed [ccmt_pkg::SCORE_W-1:0]    rsp_score_c,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [ccmt_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [ccmt_pkg::WEIGHT_W-1:0]          csr_data
);

   import ccmt_pkg::*;

   localparam int ADDR_W     = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
   localparam int CNT_W      = $clog2(MINIMA_KEPT + 1);
   localparam int PIX_WORD_W = $bits(curve_state_type) + CNT_W;
   localparam int MIN_WORD_W = MINIMA_KEPT * $bits(minimum_type);
   localparam int PAD        = (MINIMA_KEPT > REPORTED) ? MINIMA_KEPT : REPORTED;
   localparam int FIFO_CNT_W = $clog2(RSP_DEPTH + 1);
   localparam int OCC_W      = FIFO_CNT_W + 1;

   // configuration
   logic signed [WEIGHT_W-1:0] alpha_ff, alpha_in;
   logic signed [WEIGHT_W-1:0] beta_ff, beta_in;

   // stage 0
   logic              req_xfer;
   logic [ADDR_W-1:0] addr0;
   logic              ok0;

   // stage 1
   logic                v1_ff, op1_ff, ok1_ff, inrange1_ff;
   logic [PIXEL_W-1:0]  idx1_ff;
   logic [ADDR_W-1:0]   addr1_ff;
   logic [STEP_W-1:0]   step1_ff;
   logic [COST_W-1:0]   cost1_ff;

   logic [PIX_WORD_W-1:0] pix_rdata, pix_cur_word, pix_wdata;
   curve_state_type       state_cur, state_new;
   logic [CNT_W-1:0]      count_cur, count_new;
   record_type            rec;
   logic                  pix_we;
   logic [MIN_WORD_W-1:0] min_rdata, min_s1;
   logic signed [PROD_A_W-1:0] prod_a;
   logic signed [PROD_B_W-1:0] prod_b;

   logic                  pf_v_ff;
   logic [ADDR_W-1:0]     pf_addr_ff;
   logic [PIX_WORD_W-1:0] pf_data_ff;

   // stage 2
   logic                       v2_ff, op2_ff, rec2_ff, inrange2_ff;
   logic [PIXEL_W-1:0]         idx2_ff;
   logic [ADDR_W-1:0]          addr2_ff;
   logic [CNT_W-1:0]           count2_ff;
   logic [CENTER_W-1:0]        center2_ff;
   logic signed [PROD_A_W-1:0] prod_a2_ff;
   logic signed [PROD_B_W-1:0] prod_b2_ff;
   logic [MIN_WORD_W-1:0]      list2_ff;

   logic signed [SCORE_W-1:0]            score2;
   minimum_type [MINIMA_KEPT-1:0]        list_cur, list_new;
   minimum_type [PAD-1:0]                padded;
   logic                                 min_we;
   logic [COUNT_OUT_W-1:0]               cnt_rep;

   logic                  mf_v_ff;
   logic [ADDR_W-1:0]     mf_addr_ff;
   logic [MIN_WORD_W-1:0] mf_data_ff;

   // response path
   rsp_type               rsp_push_data, rsp_out;
   logic                  rsp_push;
   logic [FIFO_CNT_W-1:0] fifo_count;
   logic [OCC_W-1:0]      occ;

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;

   always_comb begin
      alpha_in = alpha_ff;
      beta_in  = beta_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CENTER_WEIGHT: alpha_in = csr_data;
            CSR_COST_WEIGHT:   beta_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= CENTER_WEIGHT_RST;
         beta_ff  <= COST_WEIGHT_RST;
      end else begin
         alpha_ff <= alpha_in;
         beta_ff  <= beta_in;
      end
   end

   // ---------------------------------------------------------------- stage 0
   assign occ       = OCC_W'(fifo_count) + OCC_W'(v1_ff && (op1_ff == OP_READ))
                    + OCC_W'(v2_ff && (op2_ff == OP_READ));
   assign req_ready = (occ < OCC_W'(RSP_DEPTH));
   assign req_xfer  = req_valid && req_ready;
   assign addr0     = ADDR_W'(req_pixel_index);
   assign ok0       = (32'(req_shift_step) < SHIFT_STEPS);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= req_xfer;
      end
   end

   always_ff @(posedge clock) begin
      op1_ff      <= req_op;
      idx1_ff     <= req_pixel_index;
      addr1_ff    <= addr0;
      step1_ff    <= req_shift_step;
      cost1_ff    <= req_pixel_cost;
      inrange1_ff <= (32'(req_pixel_index) < PIXEL_COUNT);
      ok1_ff      <= ok0 && (32'(req_pixel_index) < PIXEL_COUNT);
   end

   ccmt_ram #(.WIDTH(PIX_WORD_W), .DEPTH(PIXEL_COUNT)) u_pixel_ram (
      .clock (clock),
      .we    (pix_we),
      .waddr (addr1_ff),
      .wdata (pix_wdata),
      .raddr (addr0),
      .rdata (pix_rdata)
   );

   ccmt_ram #(.WIDTH(MIN_WORD_W), .DEPTH(PIXEL_COUNT)) u_minima_ram (
      .clock (clock),
      .we    (min_we),
      .waddr (addr2_ff),
      .wdata (list_new),
      .raddr (addr0),
      .rdata (min_rdata)
   );

   // ---------------------------------------------------------------- stage 1
   assign pix_cur_word = (pf_v_ff && pf_addr_ff == addr1_ff) ? pf_data_ff : pix_rdata;
   assign {count_cur, state_cur} = pix_cur_word;
   assign min_s1 = (mf_v_ff && mf_addr_ff == addr1_ff) ? mf_data_ff : min_rdata;

   ccmt_curve_step #(.MINIMA_KEPT(MINIMA_KEPT)) u_curve_step (
      .state_in  (state_cur),
      .count_in  (count_cur),
      .step      (step1_ff),
      .cost      (cost1_ff),
      .state_out (state_new),
      .count_out (count_new),
      .rec       (rec)
   );

   assign pix_we    = v1_ff && (op1_ff == OP_UPDATE) && ok1_ff;
   assign pix_wdata = {count_new, state_new};
   assign prod_a    = alpha_ff * $signed({1'b0, rec.center});
   assign prod_b    = beta_ff * $signed({1'b0, state_cur.last_cost});

   always_ff @(posedge clock) begin
      if (reset) begin
         pf_v_ff <= 1'b0;
         v2_ff   <= 1'b0;
      end else begin
         pf_v_ff <= pix_we;
         v2_ff   <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      pf_addr_ff  <= addr1_ff;
      pf_data_ff  <= pix_wdata;
      op2_ff      <= op1_ff;
      rec2_ff     <= pix_we && rec.record && (step1_ff != '0);
      inrange2_ff <= inrange1_ff;
      idx2_ff     <= idx1_ff;
      addr2_ff    <= addr1_ff;
      count2_ff   <= count_cur;
      center2_ff  <= rec.center;
      prod_a2_ff  <= prod_a;
      prod_b2_ff  <= prod_b;
      list2_ff    <= min_s1;
   end

   // ---------------------------------------------------------------- stage 2
   assign list_cur = (mf_v_ff && mf_addr_ff == addr2_ff) ? mf_data_ff : list2_ff;
   assign score2   = SCORE_W'(prod_a2_ff) + SCORE_W'(prod_b2_ff);

   ccmt_minima_merge #(.MINIMA_KEPT(MINIMA_KEPT)) u_minima_merge (
      .list_in  (list_cur),
      .count_in (count2_ff),
      .score    (score2),
      .center   (center2_ff),
      .list_out (list_new)
   );

   assign min_we = v2_ff && (op2_ff == OP_UPDATE) && rec2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mf_v_ff <= 1'b0;
      end else begin
         mf_v_ff <= min_we;
      end
   end

   always_ff @(posedge clock) begin
      mf_addr_ff <= addr2_ff;
      mf_data_ff <= list_new;
   end

   always_comb begin
      padded = '0;
      for (int i = 0; i < MINIMA_KEPT; i++) begin
         padded[i] = list_cur[i];
      end
      if (!inrange2_ff) begin
         cnt_rep = '0;
      end else if (count2_ff > REPORTED) begin
         cnt_rep = COUNT_OUT_W'(REPORTED);
      end else begin
         cnt_rep = COUNT_OUT_W'(count2_ff);
      end
      rsp_push_data              = '0;
      rsp_push_data.read_pixel   = idx2_ff;
      rsp_push_data.minima_count = cnt_rep;
      for (int k = 0; k < REPORTED; k++) begin
         if (k < cnt_rep) begin
            rsp_push_data.center[k] = padded[k].center;
            rsp_push_data.score[k]  = padded[k].score;
         end
      end
   end

   assign rsp_push = v2_ff && (op2_ff == OP_READ);

   ccmt_rsp_fifo #(.DEPTH(RSP_DEPTH)) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_push_data),
      .pop       (rsp_ready),
      .out_valid (rsp_valid),
      .out_data  (rsp_out),
      .count     (fifo_count)
   );

   assign rsp_read_pixel   = rsp_out.read_pixel;
   assign rsp_minima_count = rsp_out.minima_count;
   assign rsp_center_a     = rsp_out.center[0];
   assign rsp_center_b     = rsp_out.center[1];
   assign rsp_center_c     = rsp_out.center[2];
   assign rsp_score_a      = $signed(rsp_out.score[0]);
   assign rsp_score_b      = $signed(rsp_out.score[1]);
   assign rsp_score_c      = $signed(rsp_out.score[2]);

   // ---------------------------------------------------------------- checks
   a_queue_room : assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> (fifo_count < FIFO_CNT_W'(RSP_DEPTH)))
      else $error("response queue overflow");

   a_minima_follows_pixel : assert property (@(posedge clock) disable iff (reset)
      min_we |-> ($past(pix_we) && ($past(addr1_ff) == addr2_ff)))
      else $error("minima write without matching pixel update");

   a_read_reaches_output : assert property (@(posedge clock) disable iff (reset)
      rsp_push |=> rsp_valid)
      else $error("read result lost");

endmodule

// ----- design/ccmt_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccmt_ram
// Simple dual port RAM, one write and one registered read per cycle.
// A read of the address written in the same cycle returns the old data.
// ----------------------------------------------------------------------------
module ccmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/ccmt_curve_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccmt_curve_step
// Per pixel curve follower: plateau tracking and minimum detection for one
// cost sample, with the next state of the pixel entry.
// ----------------------------------------------------------------------------
module ccmt_curve_step #(
   parameter int MINIMA_KEPT = 3,
   localparam int CNT_W = $clog2(MINIMA_KEPT + 1)
) (
   input  ccmt_pkg::curve_state_type          state_in,
   input  logic [CNT_W-1:0]                   count_in,
   input  logic [ccmt_pkg::STEP_W-1:0]        step,
   input  logic [ccmt_pkg::COST_W-1:0]        cost,
   output ccmt_pkg::curve_state_type          state_out,
   output logic [CNT_W-1:0]                   count_out,
   output ccmt_pkg::record_type               rec
);

   import ccmt_pkg::*;

   logic signed [FLAT_W-1:0] flat;
   logic signed [FLAT_W-1:0] flat_open;
   logic [FLAT_W-1:0]        center_sum;

   always_comb begin
      state_out  = state_in;
      count_out  = count_in;
      rec        = '0;
      flat       = state_in.flat_start;
      flat_open  = state_in.flat_start;
      center_sum = '0;
      if (step == '0) begin
         state_out.last_cost  = cost;
         state_out.older_cost = COST_NONE;
         state_out.flat_start = FLAT_NONE;
         count_out            = '0;
      end else begin
         if (step == STEP_W'(1)) begin
            if (cost == state_in.last_cost) begin
               flat = '0;
            end else if (cost > state_in.last_cost) begin
               rec.record = 1'b1;
            end
         end else if (cost < state_in.last_cost) begin
            flat = FLAT_NONE;
         end else begin
            if (flat < 0 && {1'b0, state_in.last_cost} < state_in.older_cost) begin
               flat_open = $signed({1'b0, step}) - 11'sd1;
            end
            if (cost > state_in.last_cost && flat_open >= 0) begin
               center_sum = $unsigned(flat_open) + {1'b0, step} - 11'd1;
               rec.record = 1'b1;
               rec.center = (flat_open > 0) ? center_sum[FLAT_W-1:1] : '0;
               flat       = FLAT_NONE;
            end else begin
               flat = flat_open;
            end
         end
         state_out.flat_start = flat;
         state_out.older_cost = {1'b0, state_in.last_cost};
         state_out.last_cost  = cost;
         if (rec.record && count_in < MINIMA_KEPT) begin
            count_out = CNT_W'(count_in + 1'b1);
         end
      end
   end

endmodule

// ----- design/ccmt_minima_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccmt_minima_merge
// Inserts a new minimum into a pixel's list: append while there is room,
// otherwise replace the first worst entry when the new score is smaller.
// ----------------------------------------------------------------------------
module ccmt_minima_merge #(
   parameter int MINIMA_KEPT = 3,
   localparam int CNT_W = $clog2(MINIMA_KEPT + 1),
   localparam int IDX_W = (MINIMA_KEPT > 1) ? $clog2(MINIMA_KEPT) : 1
) (
   input  ccmt_pkg::minimum_type [MINIMA_KEPT-1:0] list_in,
   input  logic [CNT_W-1:0]                        count_in,
   input  logic signed [ccmt_pkg::SCORE_W-1:0]     score,
   input  logic [ccmt_pkg::CENTER_W-1:0]           center,
   output ccmt_pkg::minimum_type [MINIMA_KEPT-1:0] list_out
);

   import ccmt_pkg::*;

   logic [IDX_W-1:0]          worst;
   logic signed [SCORE_W-1:0] worst_score;
   minimum_type               entry;

   always_comb begin
      entry.center = center;
      entry.score  = score;
      list_out     = list_in;
      worst        = '0;
      worst_score  = $signed(list_in[0].score);
      for (int i = 1; i < MINIMA_KEPT; i++) begin
         if ($signed(list_in[i].score) > worst_score) begin
            worst       = IDX_W'(i);
            worst_score = $signed(list_in[i].score);
         end
      end
      if (count_in < MINIMA_KEPT) begin
         for (int i = 0; i < MINIMA_KEPT; i++) begin
            if (count_in == CNT_W'(i)) begin
               list_out[i] = entry;
            end
         end
      end else if (score < worst_score) begin
         for (int i = 0; i < MINIMA_KEPT; i++) begin
            if (worst == IDX_W'(i)) begin
               list_out[i] = entry;
            end
         end
      end
   end

endmodule

// ----- design/ccmt_rsp_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccmt_rsp_fifo
// Response queue between the pipeline and the result channel.
// ----------------------------------------------------------------------------
module ccmt_rsp_fifo #(
   parameter int DEPTH = 4,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ccmt_pkg::rsp_type push_data,
   input  logic              pop,
   output logic              out_valid,
   output ccmt_pkg::rsp_type out_data,
   output logic [CNT_W-1:0]  count
);

   import ccmt_pkg::*;

   rsp_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop_ok;

   assign pop_ok = pop && (count_ff != '0);

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (push && !pop_ok) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (!push && pop_ok) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

// ----- tb/tb_cost_curve_minimum_tracker_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cost_curve_minimum_tracker_unit
// Self-checking bench for the cost curve minimum tracker. Cost curves for a
// small pool of pixels are streamed in, with plateaus, rises and falls, and
// read back under several weight settings. A scoreboard follows every pixel
// curve on its own and checks each read response field by field. Both
// channels idle at random, and the response side is held off once for a long
// stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_cost_curve_minimum_tracker_unit;

   import ccmt_pkg::*;

   localparam int PIXEL_COUNT  = 65536;
   localparam int SHIFT_STEPS  = 1024;
   localparam int MINIMA_KEPT  = 3;
   localparam int POOL_SIZE    = 20;
   localparam int SEGMENTS     = 6;
   localparam int SEG_ITEMS    = 220;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 3000;

   class minima_scoreboard;
      int alpha_q88;
      int beta_q88;
      int last_cost [int];
      int older_cost [int];
      int flat_start [int];
      int found_count [int];
      int min_center [int];
      longint min_score [int];
      rsp_type expected_reports [$];
      int failures;
      int checked;

      function new();
         alpha_q88 = int'($signed(CENTER_WEIGHT_RST));
         beta_q88 = int'($signed(COST_WEIGHT_RST));
         failures = 0;
         checked = 0;
      endfunction

      function void set_weight(csr_index_type idx, logic [WEIGHT_W-1:0] data);
         if (idx == CSR_CENTER_WEIGHT) begin
            alpha_q88 = int'($signed(data));
         end else if (idx == CSR_COST_WEIGHT) begin
            beta_q88 = int'($signed(data));
         end
      endfunction

      function longint weigh(int center, int cost);
         return longint'(alpha_q88) * longint'(center) + longint'(beta_q88) * longint'(cost);
      endfunction

      function void record_minimum(int p, int center, longint score);
         int n;
         int worst;
         n = found_count[p];
         if (n > MINIMA_KEPT) n = MINIMA_KEPT;
         if (n < MINIMA_KEPT) begin
            min_center[p * MINIMA_KEPT + n] = center & 'h3FF;
            min_score[p * MINIMA_KEPT + n] = score;
            found_count[p] = n + 1;
            return;
         end
         worst = 0;
         for (int i = 1; i < MINIMA_KEPT; i++) begin
            if (min_score[p * MINIMA_KEPT + i] > min_score[p * MINIMA_KEPT + worst]) worst = i;
         end
         if (score < min_score[p * MINIMA_KEPT + worst]) begin
            min_center[p * MINIMA_KEPT + worst] = center & 'h3FF;
            min_score[p * MINIMA_KEPT + worst] = score;
         end
      endfunction

      function void follow_cost(int p, int step, int cost);
         int prev;
         int flat;
         int center;
         if (p >= PIXEL_COUNT || step >= SHIFT_STEPS) return;
         if (step == 0) begin
            last_cost[p] = cost;
            older_cost[p] = int'(COST_NONE);
            flat_start[p] = -1;
            found_count[p] = 0;
            return;
         end
         prev = last_cost[p];
         flat = flat_start[p];
         if (step == 1) begin
            if (cost == prev) begin
               flat = 0;
            end else if (cost > prev) begin
               record_minimum(p, 0, weigh(0, prev));
            end
         end else if (cost < prev) begin
            flat = -1;
         end else begin
            if (flat < 0 && prev < older_cost[p]) flat = step - 1;
            if (cost > prev && flat >= 0) begin
               center = (flat > 0) ? (flat + step - 1) / 2 : 0;
               flat = -1;
               record_minimum(p, center, weigh(center, prev));
            end
         end
         flat_start[p] = flat;
         older_cost[p] = prev;
         last_cost[p] = cost;
      endfunction

      function void take_request(logic op, logic [PIXEL_W-1:0] pixel,
                                 logic [STEP_W-1:0] step, logic [COST_W-1:0] cost);
         rsp_type report;
         int n;
         longint s;
         if (op == OP_UPDATE) begin
            follow_cost(int'(pixel), int'(step), int'(cost));
            return;
         end
         n = 0;
         if (int'(pixel) < PIXEL_COUNT) n = found_count[int'(pixel)];
         if (n > REPORTED) n = REPORTED;
         report.read_pixel = pixel;
         report.minima_count = COUNT_OUT_W'(n);
         for (int k = 0; k < REPORTED; k++) begin
            report.center[k] = '0;
            report.score[k] = '0;
            if (k < n) begin
               s = min_score[int'(pixel) * MINIMA_KEPT + k];
               report.center[k] = CENTER_W'(min_center[int'(pixel) * MINIMA_KEPT + k]);
               report.score[k] = s[SCORE_W-1:0];
            end
         end
         expected_reports.push_back(report);
      endfunction

      function void compare_field(string name, logic [SCORE_W-1:0] want,
                                  logic [SCORE_W-1:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            failures++;
         end
      endfunction

      function void check_report(logic [PIXEL_W-1:0] pixel, logic [COUNT_OUT_W-1:0] count,
                                 logic [CENTER_W-1:0] ca, logic [CENTER_W-1:0] cb,
                                 logic [CENTER_W-1:0] cc, logic [SCORE_W-1:0] sa,
                                 logic [SCORE_W-1:0] sb, logic [SCORE_W-1:0] sc);
         rsp_type want;
         if (expected_reports.size() == 0) begin
            $error("response for pixel %0d with no read outstanding", pixel);
            failures++;
            return;
         end
         want = expected_reports[0];
         expected_reports.delete(0);
         checked++;
         compare_field("read_pixel", SCORE_W'(want.read_pixel), SCORE_W'(pixel));
         compare_field("minima_count", SCORE_W'(want.minima_count), SCORE_W'(count));
         compare_field("center_a", SCORE_W'(want.center[0]), SCORE_W'(ca));
         compare_field("center_b", SCORE_W'(want.center[1]), SCORE_W'(cb));
         compare_field("center_c", SCORE_W'(want.center[2]), SCORE_W'(cc));
         compare_field("score_a", want.score[0], sa);
         compare_field("score_b", want.score[1], sb);
         compare_field("score_c", want.score[2], sc);
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic                       req_op;
   logic [PIXEL_W-1:0]         req_pixel_index;
   logic [STEP_W-1:0]          req_shift_step;
   logic [COST_W-1:0]          req_pixel_cost;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [PIXEL_W-1:0]         rsp_read_pixel;
   logic [COUNT_OUT_W-1:0]     rsp_minima_count;
   logic [CENTER_W-1:0]        rsp_center_a;
   logic [CENTER_W-1:0]        rsp_center_b;
   logic [CENTER_W-1:0]        rsp_center_c;
   logic signed [SCORE_W-1:0]  rsp_score_a;
   logic signed [SCORE_W-1:0]  rsp_score_b;
   logic signed [SCORE_W-1:0]  rsp_score_c;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_W-1:0]     csr_index;
   logic [WEIGHT_W-1:0]        csr_data;

   minima_scoreboard sb;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   bit hold_off_request = 1'b0;
   int idle_cycles = 0;
   int sent_items = 0;
   int sent_reads = 0;
   int weight_settings = 0;
   logic [PIXEL_W-1:0] pool [POOL_SIZE];
   bit slot_live [POOL_SIZE];

   cost_curve_minimum_tracker_unit #(
      .PIXEL_COUNT(PIXEL_COUNT),
      .SHIFT_STEPS(SHIFT_STEPS),
      .MINIMA_KEPT(MINIMA_KEPT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_pixel_index(req_pixel_index),
      .req_shift_step(req_shift_step),
      .req_pixel_cost(req_pixel_cost),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_read_pixel(rsp_read_pixel),
      .rsp_minima_count(rsp_minima_count),
      .rsp_center_a(rsp_center_a),
      .rsp_center_b(rsp_center_b),
      .rsp_center_c(rsp_center_c),
      .rsp_score_a(rsp_score_a),
      .rsp_score_b(rsp_score_b),
      .rsp_score_c(rsp_score_c),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // response side: random stalls, or one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off_request = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_report(rsp_read_pixel, rsp_minima_count, rsp_center_a, rsp_center_b,
                         rsp_center_c, rsp_score_a, rsp_score_b, rsp_score_c);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   task automatic send_item(logic op, logic [PIXEL_W-1:0] pixel, logic [STEP_W-1:0] step,
                            logic [COST_W-1:0] cost);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_pixel_index <= pixel;
      req_shift_step <= step;
      req_pixel_cost <= cost;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.take_request(op, pixel, step, cost);
      sent_items++;
      if (op == OP_READ) sent_reads++;
   endtask

   // lower valid, wait for all outstanding reads, then let the pipeline settle
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [WEIGHT_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_weight(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_weights(logic [WEIGHT_W-1:0] alpha, logic [WEIGHT_W-1:0] beta);
      drain();
      write_csr(CSR_CENTER_WEIGHT, alpha);
      write_csr(CSR_COST_WEIGHT, beta);
      weight_settings++;
   endtask

   function automatic int pick_live();
      int k;
      do k = $urandom_range(0, POOL_SIZE - 1); while (!slot_live[k]);
      return k;
   endfunction

   function automatic int next_cost(int c);
      int n;
      if ($urandom_range(7) == 0) begin
         n = int'($urandom_range(0, 65535));
      end else begin
         n = c + int'($urandom_range(0, 6)) - 3;
      end
      if (n < 0) n = 0;
      if (n > 65535) n = 65535;
      return n;
   endfunction

   task automatic send_read(int slot);
      send_item(OP_READ, pool[slot], STEP_W'($urandom), COST_W'($urandom));
   endtask

   // one well-formed curve: step 0, step 1, then a run of steps with occasional reads, then a read
   task automatic run_curve(int slot);
      int len;
      int base;
      int cost;
      len = $urandom_range(3, 40);
      case ($urandom_range(3))
         0: cost = $urandom_range(0, 8);
         1: cost = 65535 - int'($urandom_range(0, 8));
         default: cost = $urandom_range(0, 65535);
      endcase
      send_item(OP_UPDATE, pool[slot], '0, COST_W'(cost));
      slot_live[slot] = 1'b1;
      base = ($urandom_range(3) == 0) ? int'($urandom_range(2, 1023 - len)) : 2;
      for (int s = 1; s <= len; s++) begin
         cost = next_cost(cost);
         send_item(OP_UPDATE, pool[slot], STEP_W'((s == 1) ? 1 : base + s - 2), COST_W'(cost));
         if ($urandom_range(9) == 0) send_read(pick_live());
      end
      send_read(slot);
   endtask

   task automatic run_random(int count);
      int goal;
      int r;
      goal = sent_items + count;
      while (sent_items < goal) begin
         r = $urandom_range(99);
         if (r < 75) begin
            run_curve($urandom_range(0, POOL_SIZE - 1));
         end else if (r < 90) begin
            send_item(OP_UPDATE, pool[pick_live()], STEP_W'($urandom), COST_W'($urandom));
         end else begin
            send_read(pick_live());
         end
      end
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_UPDATE;
      req_pixel_index = '0;
      req_shift_step = '0;
      req_pixel_cost = '0;
      csr_valid = 1'b0;
      csr_index = CSR_CENTER_WEIGHT;
      csr_data = '0;
      pool[0] = 16'd0;
      pool[1] = 16'hFFFF;
      pool[2] = 16'd1;
      pool[3] = 16'd2;
      for (int k = 4; k < POOL_SIZE; k++) pool[k] = PIXEL_W'($urandom);
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part under reset weights
      req_idle_pct = 25;
      rsp_idle_pct = 80;
      send_item(OP_UPDATE, 16'd2, 10'd0, 16'd7);
      send_item(OP_READ, 16'd2, 10'd1023, 16'hFFFF);
      send_item(OP_UPDATE, 16'd0, 10'd0, 16'd100);
      send_item(OP_UPDATE, 16'd0, 10'd1, 16'd200);
      send_item(OP_READ, 16'd0, 10'd0, 16'd0);
      // flat start at step 0 closes with center 0
      send_item(OP_UPDATE, 16'hFFFF, 10'd0, 16'd0);
      send_item(OP_UPDATE, 16'hFFFF, 10'd1, 16'd0);
      send_item(OP_UPDATE, 16'hFFFF, 10'd2, 16'hFFFF);
      send_item(OP_READ, 16'hFFFF, 10'd0, 16'd0);
      // plateaus, fill the list, then replace the worst
      send_item(OP_UPDATE, 16'd1, 10'd0, 16'd50);
      send_item(OP_UPDATE, 16'd1, 10'd1, 16'd40);
      send_item(OP_UPDATE, 16'd1, 10'd2, 16'd30);
      send_item(OP_UPDATE, 16'd1, 10'd3, 16'd30);
      send_item(OP_UPDATE, 16'd1, 10'd4, 16'd30);
      send_item(OP_UPDATE, 16'd1, 10'd5, 16'd31);
      send_item(OP_UPDATE, 16'd1, 10'd6, 16'd20);
      send_item(OP_UPDATE, 16'd1, 10'd7, 16'd25);
      send_item(OP_UPDATE, 16'd1, 10'd8, 16'd10);
      send_item(OP_UPDATE, 16'd1, 10'd9, 16'd12);
      send_item(OP_UPDATE, 16'd1, 10'd10, 16'd5);
      send_item(OP_UPDATE, 16'd1, 10'd11, 16'd9);
      send_item(OP_READ, 16'd1, 10'd0, 16'd0);
      // step 1 arriving while the list is already full
      send_item(OP_UPDATE, 16'd1, 10'd1, 16'hFFFF);
      send_item(OP_READ, 16'd1, 10'd0, 16'd0);
      for (int k = 0; k < 4; k++) slot_live[k] = 1'b1;

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg)
            0: apply_weights(16'h8000, 16'h7FFF);
            1: apply_weights(16'h7FFF, 16'h8000);
            2: apply_weights(16'h0000, 16'h0000);
            4: apply_weights(16'h0100, 16'h0100);
            default: apply_weights(WEIGHT_W'($urandom), WEIGHT_W'($urandom));
         endcase
         if (seg < 2) begin
            req_idle_pct = 25;
            rsp_idle_pct = 80;
         end else if (seg < 4) begin
            req_idle_pct = 80;
            rsp_idle_pct = 25;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         if (seg == 4) begin
            // back up the response queue until the input stalls
            hold_off_request = 1'b1;
            repeat (24) send_read(pick_live());
            drain();
         end
         run_random(SEG_ITEMS);
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d request transfers (%0d reads) over %0d weight settings,",
               sent_items, sent_reads, weight_settings);
      $display("%0d responses checked, one %0d cycle response hold-off.",
               sb.checked, HOLD_CYCLES);
      if (sb.failures == 0 && sb.expected_reports.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/ccmt_pkg.sv
design/ccmt_ram.sv
design/ccmt_curve_step.sv
design/ccmt_minima_merge.sv
design/ccmt_rsp_fifo.sv
design/cost_curve_minimum_tracker_unit.sv
tb/tb_cost_curve_minimum_tracker_unit.sv
